// ===== rtl/unit_vector_deflection_defines.svh =====
// assertion macros shared by the unit vector deflection rtl
`ifndef UNIT_VECTOR_DEFLECTION_DEFINES_SVH
`define UNIT_VECTOR_DEFLECTION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UVD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define UVD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/uvd_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants, rounding and saturation helpers for the unit vector deflection block
package uvd_pkg;

   localparam int FRACTION_BITS_DEFAULT = 30;
   localparam int SQRT_WIDTH_DEFAULT    = 64;
   localparam int TRIG_BITS             = 30;

   typedef struct packed {
      logic signed [31:0] old_x;
      logic signed [31:0] old_y;
      logic signed [31:0] old_z;
      logic signed [31:0] cos_deflect;
      logic        [31:0] azimuth_turns;
   } uvd_req_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
   } uvd_rsp_type;

   // p >> sh, rounded to nearest with halves away from zero
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] p,
                                                    input int unsigned sh);
      logic [63:0] mag;
      logic [63:0] half;
      half = (64'd1 << sh) >> 1;
      mag  = p[63] ? 64'(-p) : 64'(p);
      mag  = (mag + half) >> sh;
      return p[63] ? -$signed(mag) : $signed(mag);
   endfunction

   // saturate to [-lim, lim]
   function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                              input logic signed [63:0] lim);
      logic signed [63:0] r;
      r = v;
      if (v > lim) r = lim;
      else if (v < -lim) r = -lim;
      return r;
   endfunction

endpackage

// ===== rtl/unit_vector_deflection.sv =====
`timescale 1ns / 1ps
// Unit vector deflection: turns a unit direction (Q2.F) by a polar deflection given as
// its cosine and an azimuth given as a fraction of a turn, and returns the new direction
// saturated to [-1, 1]. One word is accepted every cycle and one result word leaves per
// input word, in order. The deflection side runs two F+1 stage square roots in series
// (sin of deflection, then the z term), the frame side runs a 32 stage square root for
// sin theta and then an F+1 stage divider for the phi cosine and sine. Stalls on the
// result side freeze the whole pipeline; req_ready follows rsp_ready while the output
// register holds a word.
`include "unit_vector_deflection_defines.svh"
module unit_vector_deflection #(
   parameter int FRACTION_BITS = uvd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  uvd_pkg::uvd_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output uvd_pkg::uvd_rsp_type  rsp_data
);
   import uvd_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int SW = 2 * F + 2;   // radicand width of the deflection roots
   localparam int RW = F + 1;       // root width of the deflection roots
   localparam int MW = 35;          // width of the final products

   // stage numbers, counted from the input register (stage 1)
   localparam int SA  = F + 2;          // sin of deflection out of its root
   localparam int STX = SA + 1;         // tx, ty
   localparam int STQ = SA + 2;         // tx^2, ty^2
   localparam int STZ = STQ + F + 1;    // |tz| out of its root
   localparam int STS = STZ + 1;        // signed tz
   localparam int SB  = 33;             // sin theta out of its root
   localparam int SD  = SB + F + 1;     // quotients done
   localparam int SP  = SD + 1;         // phi cosine and sine
   localparam int SJ  = (STS > SP) ? STS : SP;
   localparam int NS  = SJ + 3;         // output register

   localparam logic signed [63:0] ONE64    = 64'sd1 <<< F;
   localparam logic signed [63:0] ONE2     = 64'sd1 <<< (2 * F);
   localparam logic signed [31:0] ONE32    = 32'sd1 <<< F;
   localparam logic signed [63:0] TRIG_ONE = 64'sd1 <<< TRIG_BITS;

   localparam logic [31:0]        PI_Q30  = 32'd3373259426;
   localparam logic [29:0]        OCTANT  = 30'h2000_0000;
   localparam logic [30:0]        QUARTER = 31'h4000_0000;
   localparam logic signed [31:0] SIN_K3  = 32'sd213044;
   localparam logic signed [31:0] SIN_K2  = 32'sd8947849;
   localparam logic signed [31:0] SIN_K1  = -32'sd178956971;
   localparam logic signed [31:0] COS_K3  = 32'sd26631;
   localparam logic signed [31:0] COS_K2  = -32'sd1491308;
   localparam logic signed [31:0] COS_K1  = 32'sd44739243;
   localparam logic signed [31:0] COS_K0  = -32'sd536870912;

   localparam int TS = TRIG_BITS;

   typedef struct packed {
      logic signed [31:0] old_x;
      logic signed [31:0] old_y;
      logic signed [31:0] old_z;
      logic               neg_cd;
   } uvd_ctx_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] x2;
      logic signed [31:0] ps;
      logic signed [31:0] pc;
      logic [1:0]         quad;
      logic               swap;
   } uvd_trig_type;

   // pipeline control
   logic          pipe_en;
   logic [NS:1]   valid_ff;

   // operands carried along
   uvd_ctx_type   ctx_ff [1:SJ];

   // azimuth sine and cosine
   uvd_trig_type        tr_ff [1:6];
   uvd_trig_type        tr_in [1:6];
   logic signed [31:0]  saz_ff [7:SA];
   logic signed [31:0]  caz_ff [7:SA];
   logic signed [31:0]  saz_in, caz_in;
   logic [29:0]         t_raw, t_fold;
   logic                fold;
   logic [61:0]         ang_prod, ang_rnd;
   logic signed [31:0]  s0, c0;

   // deflection side
   logic signed [63:0]  cd2_ff;
   logic signed [63:0]  arg_a, arg_c;
   logic [SW-1:0]       rad_a, rad_c;
   logic [RW-1:0]       root_a, root_c;
   logic signed [31:0]  tx_in, ty_in;
   logic signed [31:0]  tx_ff [STX:SJ];
   logic signed [31:0]  ty_ff [STX:SJ];
   logic signed [63:0]  tx2_ff, ty2_ff;
   logic signed [31:0]  tz_in;
   logic signed [31:0]  tz_ff [STS:SJ];

   // frame side
   logic signed [63:0]  sqx_ff, sqy_ff;
   logic [63:0]         rad_b;
   logic [31:0]         root_b;
   logic [31:0]         sth_ff [SB+1:SJ];
   logic [32:0]         rx_ff [SB+1:SD];
   logic [32:0]         ry_ff [SB+1:SD];
   logic [F:0]          qx_ff [SB+1:SD];
   logic [F:0]          qy_ff [SB+1:SD];
   logic [32:0]         rx_in [SB+1:SD];
   logic [32:0]         ry_in [SB+1:SD];
   logic [F:0]          qx_in [SB+1:SD];
   logic [F:0]          qy_in [SB+1:SD];
   logic signed [32:0]  oxe, oye;
   logic [32:0]         ax, ay, remx, remy, den;
   logic                gx, gy;
   logic signed [31:0]  cosph_in, sinph_in;
   logic signed [31:0]  cosph_ff [SP:SJ];
   logic signed [31:0]  sinph_ff [SP:SJ];

   // rotation
   logic signed [MW-1:0] tzx_ff, tzy_ff, tzz_ff, mcc_ff, mcs_ff, tys_ff, tyc_ff, txs_ff;
   logic signed [31:0]   txm_ff;
   logic signed [MW:0]   sx_ff, sy_ff, sz_ff;
   logic signed [MW-1:0] dx_ff, dy_ff;
   uvd_ctx_type          cj;
   uvd_rsp_type          out_ff;

   // the whole pipeline moves unless a finished word is waiting and rsp_ready is low
   assign pipe_en   = !valid_ff[NS] || rsp_ready;
   assign req_ready = pipe_en;
   assign rsp_valid = valid_ff[NS];
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[NS-1:1], req_valid};
      end
   end

   // azimuth: fold into the first octant, then Horner steps one multiply per stage
   always_comb begin
      t_raw    = req_data.azimuth_turns[29:0];
      fold     = t_raw > OCTANT;
      t_fold   = fold ? 30'(QUARTER - 31'(t_raw)) : t_raw;
      ang_prod = t_fold * PI_Q30;
      ang_rnd  = ang_prod + 62'(QUARTER);

      tr_in[1]      = '0;
      tr_in[1].x    = $signed({1'b0, ang_rnd[61:31]});
      tr_in[1].quad = req_data.azimuth_turns[31:30];
      tr_in[1].swap = fold;

      tr_in[2]    = tr_ff[1];
      tr_in[2].x2 = 32'(rnd_shift(tr_ff[1].x * tr_ff[1].x, TS));

      tr_in[3]    = tr_ff[2];
      tr_in[3].ps = 32'(SIN_K2 - rnd_shift(tr_ff[2].x2 * SIN_K3, TS));
      tr_in[3].pc = 32'(COS_K2 + rnd_shift(tr_ff[2].x2 * COS_K3, TS));

      tr_in[4]    = tr_ff[3];
      tr_in[4].ps = 32'(SIN_K1 + rnd_shift(tr_ff[3].x2 * tr_ff[3].ps, TS));
      tr_in[4].pc = 32'(COS_K1 + rnd_shift(tr_ff[3].x2 * tr_ff[3].pc, TS));

      tr_in[5]    = tr_ff[4];
      tr_in[5].ps = 32'(TRIG_ONE + rnd_shift(tr_ff[4].x2 * tr_ff[4].ps, TS));
      tr_in[5].pc = 32'(COS_K0 + rnd_shift(tr_ff[4].x2 * tr_ff[4].pc, TS));

      // ps becomes the octant sine, pc the octant cosine
      tr_in[6]    = tr_ff[5];
      tr_in[6].ps = 32'(sat(rnd_shift(tr_ff[5].x * tr_ff[5].ps, TS), TRIG_ONE));
      tr_in[6].pc = 32'(sat(TRIG_ONE + rnd_shift(tr_ff[5].x2 * tr_ff[5].pc, TS),
                            TRIG_ONE));

      // undo the octant fold, then rotate into the quadrant
      s0 = tr_ff[6].swap ? tr_ff[6].pc : tr_ff[6].ps;
      c0 = tr_ff[6].swap ? tr_ff[6].ps : tr_ff[6].pc;
      unique case (tr_ff[6].quad)
         2'd0: begin
            saz_in = s0;
            caz_in = c0;
         end
         2'd1: begin
            saz_in = c0;
            caz_in = -s0;
         end
         2'd2: begin
            saz_in = -s0;
            caz_in = -c0;
         end
         default: begin
            saz_in = -c0;
            caz_in = s0;
         end
      endcase
   end

   // deflection components
   always_comb begin
      arg_a = ONE2 - cd2_ff;
      rad_a = (arg_a > 0) ? arg_a[SW-1:0] : '0;
      tx_in = 32'(rnd_shift($signed({1'b0, root_a}) * caz_ff[SA], TS));
      ty_in = 32'(rnd_shift($signed({1'b0, root_a}) * saz_ff[SA], TS));
      arg_c = ONE2 - tx2_ff - ty2_ff;
      rad_c = (arg_c > 0) ? arg_c[SW-1:0] : '0;
      // backward deflection keeps the z term negative
      tz_in = ctx_ff[STZ].neg_cd ? -$signed(32'(root_c)) : $signed(32'(root_c));
      rad_b = 64'(sqx_ff) + 64'(sqy_ff);
   end

   // restoring divider for old_x / sin theta and old_y / sin theta, one bit per stage;
   // |old_x| <= sin theta, so the leading quotient bit is the only one above F-1
   always_comb begin
      oxe = 33'(ctx_ff[SB].old_x);
      oye = 33'(ctx_ff[SB].old_y);
      ax  = oxe[32] ? 33'(-oxe) : 33'(oxe);
      ay  = oye[32] ? 33'(-oye) : 33'(oye);
      den = {1'b0, root_b};
      gx  = ax >= den;
      gy  = ay >= den;
      rx_in[SB+1] = gx ? ax - den : ax;
      ry_in[SB+1] = gy ? ay - den : ay;
      qx_in[SB+1] = (F+1)'(gx);
      qy_in[SB+1] = (F+1)'(gy);
      for (int k = SB + 2; k <= SD; k++) begin
         den  = {1'b0, sth_ff[k-1]};
         remx = {rx_ff[k-1][31:0], 1'b0};
         remy = {ry_ff[k-1][31:0], 1'b0};
         gx   = remx >= den;
         gy   = remy >= den;
         rx_in[k] = gx ? remx - den : remx;
         ry_in[k] = gy ? remy - den : remy;
         qx_in[k] = {qx_ff[k-1][F-1:0], gx};
         qy_in[k] = {qy_ff[k-1][F-1:0], gy};
      end
      // direction along z: phi taken as zero
      if (sth_ff[SD] == '0) begin
         cosph_in = ONE32;
         sinph_in = '0;
      end else begin
         cosph_in = ctx_ff[SD].old_x[31] ? -$signed(32'(qx_ff[SD]))
                                         : $signed(32'(qx_ff[SD]));
         sinph_in = ctx_ff[SD].old_y[31] ? -$signed(32'(qy_ff[SD]))
                                         : $signed(32'(qy_ff[SD]));
      end
      cj = ctx_ff[SJ];
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         // stage 1
         ctx_ff[1] <= '{old_x:  req_data.old_x, old_y: req_data.old_y,
                        old_z:  req_data.old_z, neg_cd: req_data.cos_deflect[31]};
         for (int k = 2; k <= SJ; k++) ctx_ff[k] <= ctx_ff[k-1];
         cd2_ff <= req_data.cos_deflect * req_data.cos_deflect;
         sqx_ff <= req_data.old_x * req_data.old_x;
         sqy_ff <= req_data.old_y * req_data.old_y;

         // azimuth
         tr_ff     <= tr_in;
         saz_ff[7] <= saz_in;
         caz_ff[7] <= caz_in;
         for (int k = 8; k <= SA; k++) begin
            saz_ff[k] <= saz_ff[k-1];
            caz_ff[k] <= caz_ff[k-1];
         end

         // deflection side
         tx_ff[STX] <= tx_in;
         ty_ff[STX] <= ty_in;
         for (int k = STX + 1; k <= SJ; k++) begin
            tx_ff[k] <= tx_ff[k-1];
            ty_ff[k] <= ty_ff[k-1];
         end
         tx2_ff <= tx_ff[STX] * tx_ff[STX];
         ty2_ff <= ty_ff[STX] * ty_ff[STX];
         tz_ff[STS] <= tz_in;
         for (int k = STS + 1; k <= SJ; k++) tz_ff[k] <= tz_ff[k-1];

         // frame side
         sth_ff[SB+1] <= root_b;
         for (int k = SB + 2; k <= SJ; k++) sth_ff[k] <= sth_ff[k-1];
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         cosph_ff[SP] <= cosph_in;
         sinph_ff[SP] <= sinph_in;
         for (int k = SP + 1; k <= SJ; k++) begin
            cosph_ff[k] <= cosph_ff[k-1];
            sinph_ff[k] <= sinph_ff[k-1];
         end

         // rotation, first products
         tzx_ff <= MW'(rnd_shift(tz_ff[SJ] * cj.old_x, F));
         tzy_ff <= MW'(rnd_shift(tz_ff[SJ] * cj.old_y, F));
         tzz_ff <= MW'(rnd_shift(tz_ff[SJ] * cj.old_z, F));
         mcc_ff <= MW'(rnd_shift(cj.old_z * cosph_ff[SJ], F));
         mcs_ff <= MW'(rnd_shift(cj.old_z * sinph_ff[SJ], F));
         tys_ff <= MW'(rnd_shift(ty_ff[SJ] * sinph_ff[SJ], F));
         tyc_ff <= MW'(rnd_shift(ty_ff[SJ] * cosph_ff[SJ], F));
         txs_ff <= MW'(rnd_shift(tx_ff[SJ] * $signed({1'b0, sth_ff[SJ]}), F));
         txm_ff <= tx_ff[SJ];

         // second products and partial sums
         dx_ff <= MW'(rnd_shift(txm_ff * mcc_ff, F));
         dy_ff <= MW'(rnd_shift(txm_ff * mcs_ff, F));
         sx_ff <= (MW+1)'(tzx_ff) - (MW+1)'(tys_ff);
         sy_ff <= (MW+1)'(tzy_ff) + (MW+1)'(tyc_ff);
         sz_ff <= (MW+1)'(tzz_ff) - (MW+1)'(txs_ff);

         // output word, saturated to one
         out_ff.new_x <= 32'(sat(sx_ff + dx_ff, ONE64));
         out_ff.new_y <= 32'(sat(sy_ff + dy_ff, ONE64));
         out_ff.new_z <= 32'(sat(64'(sz_ff), ONE64));
      end
   end

   uvd_isqrt #(.RADICAND_WIDTH(SW)) u_sqrt_sinp (
      .clock    (clock),
      .enable   (pipe_en),
      .radicand (rad_a),
      .root     (root_a)
   );

   uvd_isqrt #(.RADICAND_WIDTH(SW)) u_sqrt_tz (
      .clock    (clock),
      .enable   (pipe_en),
      .radicand (rad_c),
      .root     (root_c)
   );

   uvd_isqrt #(.RADICAND_WIDTH(64)) u_sqrt_sinth (
      .clock    (clock),
      .enable   (pipe_en),
      .radicand (rad_b),
      .root     (root_b)
   );

   `UVD_ASSERT_NXT(a_accept_enters, clock, reset, req_valid && req_ready, valid_ff[1], "accepted word missing from first stage")
   `UVD_ASSERT_NXT(a_stall_freezes, clock, reset, !pipe_en, $stable(valid_ff), "pipeline moved during a stall")
   `UVD_ASSERT_IMP(a_phi_unit, clock, reset, valid_ff[SP], cosph_ff[SP] <= ONE32 && cosph_ff[SP] >= -ONE32 && sinph_ff[SP] <= ONE32 && sinph_ff[SP] >= -ONE32, "phi cosine or sine beyond one")
   `UVD_ASSERT_IMP(a_out_bounded, clock, reset, rsp_valid, rsp_data.new_x <= ONE32 && rsp_data.new_x >= -ONE32 && rsp_data.new_y <= ONE32 && rsp_data.new_y >= -ONE32 && rsp_data.new_z <= ONE32 && rsp_data.new_z >= -ONE32, "result word beyond unit range")

endmodule

// ===== rtl/uvd_isqrt.sv =====
`timescale 1ns / 1ps
// pipelined floor integer square root, one root bit per stage
module uvd_isqrt #(
   parameter int RADICAND_WIDTH = uvd_pkg::SQRT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [RADICAND_WIDTH-1:0]     radicand,
   output logic [RADICAND_WIDTH/2-1:0]   root
);
   import uvd_pkg::*;

   localparam int N  = RADICAND_WIDTH / 2;
   localparam int RW = N + 3;

   typedef struct packed {
      logic [RADICAND_WIDTH-1:0] rad;
      logic [RW-1:0]             rem;
      logic [N-1:0]              root;
   } sq_stage_type;

   function automatic sq_stage_type sq_step(input sq_stage_type s);
      sq_stage_type  r;
      logic [RW-1:0] cur;
      logic [RW-1:0] trial;
      cur   = {s.rem[RW-3:0], s.rad[RADICAND_WIDTH-1 -: 2]};
      trial = RW'({s.root, 2'b01});
      r.rad = s.rad << 2;
      if (cur >= trial) begin
         r.rem  = cur - trial;
         r.root = {s.root[N-2:0], 1'b1};
      end else begin
         r.rem  = cur;
         r.root = {s.root[N-2:0], 1'b0};
      end
      return r;
   endfunction

   sq_stage_type st_ff [N];
   sq_stage_type st_in [N];

   always_comb begin
      st_in[0] = sq_step({radicand, RW'(0), N'(0)});
      for (int i = 1; i < N; i++) begin
         st_in[i] = sq_step(st_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff <= st_in;
      end
   end

   assign root = st_ff[N-1].root;

endmodule
